FILE: hw/rtl/ale_pkg.sv
// Shared types and constants of the array list engine.
package ale_pkg;

    localparam int ADDR_MAX_W = 10;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4,
        CMD_MODIFY     = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_DOWN,
        S_SRCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_MAX_W-1:0] waddr;
        logic [31:0]           wdata;
        logic                  re;
        logic [ADDR_MAX_W-1:0] raddr;
    } mem_req_t;

endpackage

FILE: hw/rtl/ale_mem.sv
// Entry storage of the array list engine: one write port and one registered read port.
module ale_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              clk,
    input  ale_pkg::mem_req_t req,
    output logic [31:0]       rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/ale_ctrl.sv
// Command sequencer of the array list engine: shift and search passes, count and result register.
module ale_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          command,
    input  logic signed [31:0]  value,
    input  logic [3:0]          position,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic                found,
    output logic [3:0]          found_index,
    output logic [4:0]          item_count,
    output ale_pkg::mem_req_t   req,
    input  logic [31:0]         rdata
);

    localparam int AMW = ale_pkg::ADDR_MAX_W;

    ale_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    left_reg, left_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    dst_reg, dst_next;
    logic             pend_reg, pend_next;
    logic [31:0]      value_reg, value_next;
    ale_pkg::status_t res_status_reg, res_status_next;
    logic             res_found_reg, res_found_next;
    logic [AW-1:0]    res_idx_reg, res_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic             out_found_reg, out_found_next;
    logic [3:0]       out_idx_reg, out_idx_next;
    logic [4:0]       out_count_reg, out_count_next;

    logic             full;
    logic             empty;
    logic             hit;
    logic [CW-1:0]    count_m1;
    logic [31:0]      count_ext;
    logic [31:0]      res_idx_ext;

    assign full        = (count_reg == CW'(DEPTH));
    assign empty       = (count_reg == '0);
    assign hit         = pend_reg && (rdata == value_reg);
    assign count_m1    = count_reg - CW'(1);
    assign count_ext   = 32'(count_reg);
    assign res_idx_ext = 32'(res_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ale_pkg::S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg       <= left_next;
        idx_reg        <= idx_next;
        dst_reg        <= dst_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_idx_reg    <= res_idx_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_idx_reg    <= out_idx_next;
        out_count_reg  <= out_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        left_next       = left_reg;
        idx_next        = idx_reg;
        dst_next        = dst_reg;
        pend_next       = pend_reg;
        value_next      = value_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_idx_next    = res_idx_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_idx_next    = out_idx_reg;
        out_count_next  = out_count_reg;
        req             = '0;
        in_ready        = (state_reg == ale_pkg::S_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ale_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    value_next      = value;
                    res_status_next = ale_pkg::ST_OK;
                    res_found_next  = 1'b0;
                    res_idx_next    = '0;
                    pend_next       = 1'b0;
                    state_next      = ale_pkg::S_DONE;
                    unique case (ale_pkg::cmd_t'(command))
                        ale_pkg::CMD_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_status_next = ale_pkg::ST_FULL;
                            end
                            else
                            begin
                                left_next  = count_reg;
                                idx_next   = count_m1[AW-1:0];
                                state_next = ale_pkg::S_UP;
                            end
                        end
                        ale_pkg::CMD_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_status_next = ale_pkg::ST_FULL;
                            end
                            else
                            begin
                                req.we     = 1'b1;
                                req.waddr  = AMW'(count_reg);
                                req.wdata  = value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ale_pkg::CMD_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_status_next = ale_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                left_next  = count_m1;
                                idx_next   = AW'(1);
                                state_next = ale_pkg::S_DOWN;
                            end
                        end
                        ale_pkg::CMD_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_status_next = ale_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_m1;
                            end
                        end
                        ale_pkg::CMD_SEARCH:
                        begin
                            left_next  = count_reg;
                            idx_next   = '0;
                            state_next = ale_pkg::S_SRCH;
                        end
                        ale_pkg::CMD_MODIFY:
                        begin
                            if (32'(position) < count_ext)
                            begin
                                req.we    = 1'b1;
                                req.waddr = AMW'(position);
                                req.wdata = value;
                            end
                            else
                            begin
                                res_status_next = ale_pkg::ST_BADPOS;
                            end
                        end
                        default:
                        begin
                            res_status_next = ale_pkg::ST_OK;
                        end
                    endcase
                end
            end
            ale_pkg::S_UP:
            begin
                if (pend_reg)
                begin
                    req.we    = 1'b1;
                    req.waddr = AMW'(dst_reg);
                    req.wdata = rdata;
                end
                if (left_reg != '0)
                begin
                    req.re    = 1'b1;
                    req.raddr = AMW'(idx_reg);
                    pend_next = 1'b1;
                    dst_next  = idx_reg + AW'(1);
                    idx_next  = idx_reg - AW'(1);
                    left_next = left_reg - CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        req.we     = 1'b1;
                        req.waddr  = '0;
                        req.wdata  = value_reg;
                        count_next = count_reg + CW'(1);
                        state_next = ale_pkg::S_DONE;
                    end
                end
            end
            ale_pkg::S_DOWN:
            begin
                if (pend_reg)
                begin
                    req.we    = 1'b1;
                    req.waddr = AMW'(dst_reg);
                    req.wdata = rdata;
                end
                if (left_reg != '0)
                begin
                    req.re    = 1'b1;
                    req.raddr = AMW'(idx_reg);
                    pend_next = 1'b1;
                    dst_next  = idx_reg - AW'(1);
                    idx_next  = idx_reg + AW'(1);
                    left_next = left_reg - CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_m1;
                        state_next = ale_pkg::S_DONE;
                    end
                end
            end
            ale_pkg::S_SRCH:
            begin
                if (hit)
                begin
                    res_found_next = 1'b1;
                    res_idx_next   = dst_reg;
                    pend_next      = 1'b0;
                    state_next     = ale_pkg::S_DONE;
                end
                else if (left_reg != '0)
                begin
                    req.re    = 1'b1;
                    req.raddr = AMW'(idx_reg);
                    pend_next = 1'b1;
                    dst_next  = idx_reg;
                    idx_next  = idx_reg + AW'(1);
                    left_next = left_reg - CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ale_pkg::S_DONE;
                    end
                end
            end
            ale_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = res_found_reg;
                    out_idx_next    = res_idx_ext[3:0];
                    out_count_next  = count_ext[4:0];
                    state_next      = ale_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ale_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found       = out_found_reg;
    assign found_index = out_idx_reg;
    assign item_count  = out_count_reg;

endmodule

FILE: hw/rtl/array_list_engine_top.sv
// Top level of the array list engine: sequencer and entry storage.
//
// An ordered list of up to DEPTH signed 32-bit words behind a command channel
// and a result channel. Push back, pop back, modify, the unused codes and any
// refused command go from transfer straight to the result state, with no walk.
// Push front, pop front and search walk the stored entries through the single
// read port of the entry memory, one entry per cycle, and a search that matches
// stops early at the matching entry. One command is worked on at a time; a new
// command is taken as soon as the previous one has produced its result, even
// while that result still waits in the output register. After reset the list
// is empty and no memory initialization is needed.
module array_list_engine_top #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         command,
    input  logic signed [31:0] value,
    input  logic [3:0]         position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               found,
    output logic [3:0]         found_index,
    output logic [4:0]         item_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ale_pkg::mem_req_t req;
    logic [31:0]       rdata;

    ale_ctrl #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .CW   (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .found      (found),
        .found_index(found_index),
        .item_count (item_count),
        .req        (req),
        .rdata      (rdata)
    );

    ale_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .clk  (clk),
        .req  (req),
        .rdata(rdata)
    );

endmodule

FILE: hw/rtl/ale_checker.sv
// Port-level checks of the array list engine and their binding to the top level.
module ale_checker #(
    parameter int DEPTH = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         status,
    input logic               found,
    input logic [3:0]         found_index,
    input logic [4:0]         item_count
);

    // A stalled result holds its value until its transfer.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found)
            && $stable(found_index) && $stable(item_count))
        else $error("stalled result changed");

    // A command transfer is always followed by a busy cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a command transfer");

    // A match is reported only by a successful command.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == ale_pkg::ST_OK)
        else $error("found set with error status");

    // A refused insert reports a full list.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ale_pkg::ST_FULL |-> item_count == 5'(DEPTH) && !found)
        else $error("full status with wrong count");

    // A refused removal reports an empty list.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ale_pkg::ST_EMPTY |-> item_count == 5'd0 && !found
            && found_index == 4'd0)
        else $error("empty status with nonzero count");

endmodule

bind array_list_engine_top ale_checker #(.DEPTH(DEPTH)) u_ale_checker (.*);

FILE: bench/tb_array_list_engine_top.sv
// Self-checking testbench for the array list engine: predicts every result and checks it.
module tb_array_list_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef struct {
        logic [1:0] status;
        logic       found;
        logic [3:0] found_index;
        logic [4:0] item_count;
    } list_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         command = 3'd0;
    logic signed [31:0] value = 32'sd0;
    logic [3:0]         position = 4'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic               found;
    logic [3:0]         found_index;
    logic [4:0]         item_count;

    logic [31:0]  list_words [DEPTH];
    int           list_len;
    list_result_t pending_results [$];
    list_result_t oldest_result;

    int mismatches;
    int cycle_count;
    int hold_request;
    int burst_left;
    bit gaps_enabled;
    int n_push, n_pop, n_search, n_modify, n_spare;
    int n_full, n_empty, n_badpos, n_match;

    array_list_engine_top #(.DEPTH(DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .item_count  (item_count)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic list_result_t list_apply(input logic [2:0] cmd, input logic [31:0] word,
                                                input logic [3:0] pos);
        list_result_t r;
        r.status = ale_pkg::ST_OK;
        r.found = 1'b0;
        r.found_index = 4'd0;
        unique case (cmd)
            ale_pkg::CMD_PUSH_FRONT:
            begin
                if (list_len >= DEPTH)
                    r.status = ale_pkg::ST_FULL;
                else
                begin
                    for (int i = list_len; i > 0; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[0] = word;
                    list_len++;
                end
            end
            ale_pkg::CMD_PUSH_BACK:
            begin
                if (list_len >= DEPTH)
                    r.status = ale_pkg::ST_FULL;
                else
                begin
                    list_words[list_len] = word;
                    list_len++;
                end
            end
            ale_pkg::CMD_POP_FRONT:
            begin
                if (list_len == 0)
                    r.status = ale_pkg::ST_EMPTY;
                else
                begin
                    for (int i = 0; i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            ale_pkg::CMD_POP_BACK:
            begin
                if (list_len == 0)
                    r.status = ale_pkg::ST_EMPTY;
                else
                    list_len--;
            end
            ale_pkg::CMD_SEARCH:
            begin
                for (int i = 0; i < list_len; i++)
                begin
                    if (!r.found && list_words[i] == word)
                    begin
                        r.found = 1'b1;
                        r.found_index = 4'(i);
                    end
                end
            end
            ale_pkg::CMD_MODIFY:
            begin
                if (int'(pos) >= list_len)
                    r.status = ale_pkg::ST_BADPOS;
                else
                    list_words[pos] = word;
            end
            default:
            begin
            end
        endcase
        r.item_count = 5'(list_len);
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        unique case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4, 5: return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_command(input logic [2:0] cmd, input logic [31:0] word,
                                input logic [3:0] pos);
        list_result_t r;
        int gap;
        command <= cmd;
        value <= word;
        position <= pos;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = list_apply(cmd, word, pos);
        pending_results.push_back(r);
        unique case (cmd)
            ale_pkg::CMD_PUSH_FRONT, ale_pkg::CMD_PUSH_BACK: n_push++;
            ale_pkg::CMD_POP_FRONT, ale_pkg::CMD_POP_BACK: n_pop++;
            ale_pkg::CMD_SEARCH: n_search++;
            ale_pkg::CMD_MODIFY: n_modify++;
            default: n_spare++;
        endcase
        if (r.status == ale_pkg::ST_FULL)
            n_full++;
        if (r.status == ale_pkg::ST_EMPTY)
            n_empty++;
        if (r.status == ale_pkg::ST_BADPOS)
            n_badpos++;
        if (r.found)
            n_match++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_enabled ? $urandom_range(1, 8) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random_commands(input int n_items, input int grow_pct);
        logic [2:0]  cmd;
        logic [31:0] word;
        logic [3:0]  pos;
        int          roll;
        for (int n = 0; n < n_items; n++)
        begin
            word = pick_word();
            pos = 4'($urandom_range(0, 15));
            roll = $urandom_range(0, 99);
            if (roll < 3)
                cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
            else if (roll < 18)
            begin
                cmd = ale_pkg::CMD_SEARCH;
                if (list_len > 0 && $urandom_range(0, 1))
                    word = list_words[$urandom_range(0, list_len - 1)];
            end
            else if (roll < 30)
            begin
                cmd = ale_pkg::CMD_MODIFY;
                if (list_len > 0 && $urandom_range(0, 3) != 0)
                    pos = 4'($urandom_range(0, list_len - 1));
            end
            else if ($urandom_range(0, 99) < grow_pct)
                cmd = $urandom_range(0, 1) ? ale_pkg::CMD_PUSH_FRONT : ale_pkg::CMD_PUSH_BACK;
            else
                cmd = $urandom_range(0, 1) ? ale_pkg::CMD_POP_FRONT : ale_pkg::CMD_POP_BACK;
            send_command(cmd, word, pos);
        end
    endtask

    task automatic test_directed_edges();
        send_command(ale_pkg::CMD_POP_FRONT, 32'h0000_0000, 4'd0);
        send_command(ale_pkg::CMD_POP_BACK, 32'hffff_ffff, 4'd15);
        send_command(ale_pkg::CMD_SEARCH, 32'h0000_0000, 4'd0);
        send_command(ale_pkg::CMD_MODIFY, 32'h1234_5678, 4'd0);
        send_command(CMD_SPARE_6, 32'hffff_ffff, 4'd15);
        send_command(CMD_SPARE_7, 32'h0000_0000, 4'd0);
        send_command(ale_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 4'd0);
        for (int i = 1; i < DEPTH; i++)
            send_command(ale_pkg::CMD_PUSH_BACK,
                         (i == 1) ? 32'h7fff_ffff : (i == 2) ? 32'h0000_0000 :
                         (i == 3) ? 32'hffff_ffff : (i == 8 || i == 12) ? 32'h0000_0005 :
                         32'(i) * 32'h0101_0101, 4'(i));
        send_command(ale_pkg::CMD_PUSH_FRONT, 32'h0000_0001, 4'd0);
        send_command(ale_pkg::CMD_PUSH_BACK, 32'h0000_0002, 4'd0);
        send_command(ale_pkg::CMD_SEARCH, 32'h0000_0005, 4'd0);
        send_command(ale_pkg::CMD_SEARCH, 32'h0f0f_0f0f, 4'd0);
        send_command(ale_pkg::CMD_MODIFY, 32'h5a5a_5a5a, 4'd15);
        send_command(ale_pkg::CMD_MODIFY, 32'ha5a5_a5a5, 4'd0);
        send_command(ale_pkg::CMD_POP_FRONT, 32'h0000_0000, 4'd0);
        send_command(ale_pkg::CMD_POP_BACK, 32'h0000_0000, 4'd0);
        send_command(ale_pkg::CMD_MODIFY, 32'h0000_0000, 4'd15);
        wait_results_drained();
    endtask

    task automatic test_fill_to_full();
        run_random_commands(200, 85);
        wait_results_drained();
    endtask

    task automatic test_empty_out();
        run_random_commands(150, 15);
        wait_results_drained();
    endtask

    task automatic test_back_to_back();
        gaps_enabled = 1'b0;
        run_random_commands(150, 55);
        gaps_enabled = 1'b1;
        wait_results_drained();
    endtask

    // The receiver holds off while commands keep coming, so the block must stall its input.
    task automatic test_output_backpressure();
        hold_request = 1;
        run_random_commands(20, 60);
        wait_results_drained();
    endtask

    task automatic test_mixed_traffic();
        run_random_commands(200, 50);
        wait_results_drained();
    endtask

    initial
    begin
        int mode;
        int seg_left;
        int hold_left;
        mode = 0;
        seg_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_request = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(16, 160);
                end
                seg_left--;
                unique case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                mismatches++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (status !== oldest_result.status)
                begin
                    $error("status: expected %0d, got %0d", oldest_result.status, status);
                    mismatches++;
                end
                if (found !== oldest_result.found)
                begin
                    $error("found: expected %0d, got %0d", oldest_result.found, found);
                    mismatches++;
                end
                if (found_index !== oldest_result.found_index)
                begin
                    $error("found_index: expected %0d, got %0d", oldest_result.found_index,
                           found_index);
                    mismatches++;
                end
                if (item_count !== oldest_result.item_count)
                begin
                    $error("item_count: expected %0d, got %0d", oldest_result.item_count,
                           item_count);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("array_list_engine_top test failed");
        $finish;
    end

    initial
    begin
        list_len = 0;
        for (int i = 0; i < DEPTH; i++)
            list_words[i] = 32'h0;
        mismatches = 0;
        hold_request = 0;
        burst_left = 0;
        gaps_enabled = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_fill_to_full();
        test_empty_out();
        test_back_to_back();
        test_output_backpressure();
        test_mixed_traffic();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            mismatches++;
        end
        $display("Covered %0d pushes, %0d pops, %0d searches, %0d modifies, %0d spare codes.",
                 n_push, n_pop, n_search, n_modify, n_spare);
        $display("Refused %0d on full, %0d on empty, %0d on bad position; %0d searches matched.",
                 n_full, n_empty, n_badpos, n_match);
        if (mismatches == 0)
            $display("array_list_engine_top test passed");
        else
            $display("array_list_engine_top test failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ale_pkg.sv
hw/rtl/ale_mem.sv
hw/rtl/ale_ctrl.sv
hw/rtl/array_list_engine_top.sv
hw/rtl/ale_checker.sv
bench/tb_array_list_engine_top.sv
